/* design/ede_pkg.sv */
// ----------------------------------------------------------------------------
// ede_pkg - shared types and helpers for the edit distance engine
// Input mode codes, the link record that runs down the cell row, and the
// saturating arithmetic that every cell uses.
// ----------------------------------------------------------------------------
package ede_pkg;

    // default reference capacity
    localparam int MAX_LEN_DEF = 64;

    // column entries and test count width
    localparam int DIST_W = 16;
    localparam int CHR_W  = 8;
    localparam int MODE_W = 2;

    // input mode codes
    localparam logic [MODE_W-1:0] MODE_REF  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TEST = 2'd1;
    localparam logic [MODE_W-1:0] MODE_END  = 2'd2;

    // record passed from one cell to the next every cycle
    typedef struct packed {
        logic              vld;     // a test byte or an end token is present
        logic              is_end;  // end token: report and clear
        logic [CHR_W-1:0]  chr;     // test byte
        logic [DIST_W-1:0] d_old;   // previous column entry of the upper cell
        logic [DIST_W-1:0] d_new;   // new column entry, or carried distance
        logic              ovf;     // dropped reference bytes, end token only
    } t_link;

    // increment that sticks at the top value
    function automatic logic [DIST_W-1:0] f_sat_inc(input logic [DIST_W-1:0] v);
        return (v == {DIST_W{1'b1}}) ? v : v + 1'b1;
    endfunction

    // smallest of three
    function automatic logic [DIST_W-1:0] f_min3(input logic [DIST_W-1:0] a,
                                                 input logic [DIST_W-1:0] b,
                                                 input logic [DIST_W-1:0] c);
        logic [DIST_W-1:0] m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

endpackage

/* design/edit_distance_engine.sv */
// Result path: an accepted end token first enters the front launch register.
// Throughput: one transaction per cycle; an end transaction waits while the previous
//   end token is still in the row or its result has not been taken.
// The end token walks one cell per cycle down the row, then loads the result register.
// Reset: synchronous active low; all pair state is cleared, no result is pending.
// ----------------------------------------------------------------------------
// edit_distance_engine - Levenshtein distance on a systolic row of cells
// Reference bytes load into the cells, test bytes sweep the row as a
// wavefront, and an end token collects the distance and clears each cell.
// ----------------------------------------------------------------------------
module edit_distance_engine #(
    parameter int MAX_LEN = ede_pkg::MAX_LEN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] character
    input  logic [1:0]  s_axis_tuser,   // [1:0] mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] distance
    output logic [0:0]  m_axis_tuser    // [0] overflow
);

    localparam int CNT_W = $clog2(MAX_LEN + 1);

    ede_pkg::t_link             w_link [MAX_LEN+1];
    logic                       w_acc;
    logic                       w_wr_en;
    logic [CNT_W-1:0]           w_wr_idx;
    logic [ede_pkg::CHR_W-1:0]  w_wr_chr;
    logic                       w_tok_out;

    logic                       r_busy, n_busy;
    logic                       r_out_vld, n_out_vld;
    logic [ede_pkg::DIST_W-1:0] r_dist;
    logic                       r_ovf;

    // an end transaction needs a free row and a free result slot
    assign s_axis_tready = !((s_axis_tuser == ede_pkg::MODE_END) && (r_busy || r_out_vld));
    assign w_acc         = s_axis_tvalid && s_axis_tready;

    ede_front #(
        .MAX_LEN (MAX_LEN),
        .CNT_W   (CNT_W)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_acc    (w_acc),
        .i_mode   (s_axis_tuser),
        .i_chr    (s_axis_tdata),
        .o_link   (w_link[0]),
        .o_wr_en  (w_wr_en),
        .o_wr_idx (w_wr_idx),
        .o_wr_chr (w_wr_chr)
    );

    // row of cells, one per reference position
    for (genvar g = 1; g <= MAX_LEN; g++) begin : g_cell
        ede_cell #(
            .CELL_IDX (g),
            .CNT_W    (CNT_W)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_link   (w_link[g-1]),
            .i_wr_en  (w_wr_en),
            .i_wr_idx (w_wr_idx),
            .i_wr_chr (w_wr_chr),
            .o_link   (w_link[g])
        );
    end

    assign w_tok_out = w_link[MAX_LEN].vld && w_link[MAX_LEN].is_end;

    // token tracking and result slot
    always_comb begin
        n_busy    = r_busy;
        n_out_vld = r_out_vld;
        if (w_acc && (s_axis_tuser == ede_pkg::MODE_END)) begin
            n_busy = 1'b1;
        end else if (w_tok_out) begin
            n_busy = 1'b0;
        end
        if (w_tok_out) begin
            n_out_vld = 1'b1;
        end else if (m_axis_tready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_busy    <= n_busy;
            r_out_vld <= n_out_vld;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_tok_out) begin
            r_dist <= w_link[MAX_LEN].d_new;
            r_ovf  <= w_link[MAX_LEN].ovf;
        end
    end

    assign m_axis_tvalid   = r_out_vld;
    assign m_axis_tdata    = r_dist;
    assign m_axis_tuser[0] = r_ovf;

endmodule

/* design/ede_cell.sv */
// ----------------------------------------------------------------------------
// ede_cell - one reference position of the edit distance row
// Holds a reference byte and its column entry, updates the entry when a test
// byte passes and hands the old and new entries to the next cell.
// ----------------------------------------------------------------------------
module ede_cell #(
    parameter int CELL_IDX = 1,
    parameter int CNT_W    = 7
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  ede_pkg::t_link           i_link,
    input  logic                     i_wr_en,
    input  logic [CNT_W-1:0]         i_wr_idx,
    input  logic [ede_pkg::CHR_W-1:0] i_wr_chr,
    output ede_pkg::t_link           o_link
);

    localparam logic [ede_pkg::DIST_W-1:0] RST_D = ede_pkg::DIST_W'(CELL_IDX);
    localparam logic [CNT_W-1:0]           MY_IDX = CNT_W'(CELL_IDX - 1);

    logic                        r_vld, n_vld;
    logic [ede_pkg::CHR_W-1:0]   r_chr, n_chr;
    logic [ede_pkg::DIST_W-1:0]  r_d, n_d;
    logic [ede_pkg::DIST_W-1:0]  w_sub, w_cand;
    ede_pkg::t_link              r_link, n_link;

    // candidate entry from the three neighbors
    always_comb begin
        w_sub  = (r_chr == i_link.chr) ? i_link.d_old : ede_pkg::f_sat_inc(i_link.d_old);
        w_cand = ede_pkg::f_min3(ede_pkg::f_sat_inc(r_d),
                                 ede_pkg::f_sat_inc(i_link.d_new), w_sub);
    end

    // cell update and forwarded record
    always_comb begin
        n_vld  = r_vld;
        n_chr  = r_chr;
        n_d    = r_d;
        n_link = i_link;
        if (i_link.vld) begin
            if (i_link.is_end) begin
                n_d   = RST_D;
                n_vld = 1'b0;
                if (r_vld) begin
                    n_link.d_new = r_d;
                end
            end else if (r_vld) begin
                n_d          = w_cand;
                n_link.d_old = r_d;
                n_link.d_new = w_cand;
            end
        end
        // a reference write wins over the clearing token
        if (i_wr_en && (i_wr_idx == MY_IDX)) begin
            n_vld = 1'b1;
            n_chr = i_wr_chr;
        end
    end

    // control state and column entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= 1'b0;
            r_d        <= RST_D;
            r_link.vld <= 1'b0;
        end else begin
            r_vld  <= n_vld;
            r_d    <= n_d;
            r_link <= n_link;
        end
    end

    // reference byte
    always_ff @(posedge i_clk) begin
        r_chr <= n_chr;
    end

    assign o_link = r_link;

endmodule

/* design/ede_front.sv */
// ----------------------------------------------------------------------------
// ede_front - input decoder and pair bookkeeping
// Tracks the reference length, the test length and the drop flag, steers
// reference bytes to their cell and launches test bytes and end tokens.
// ----------------------------------------------------------------------------
module ede_front #(
    parameter int MAX_LEN = ede_pkg::MAX_LEN_DEF,
    parameter int CNT_W   = $clog2(MAX_LEN + 1)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_acc,
    input  logic [ede_pkg::MODE_W-1:0] i_mode,
    input  logic [ede_pkg::CHR_W-1:0]  i_chr,
    output ede_pkg::t_link             o_link,
    output logic                       o_wr_en,
    output logic [CNT_W-1:0]           o_wr_idx,
    output logic [ede_pkg::CHR_W-1:0]  o_wr_chr
);

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_LEN);

    logic [CNT_W-1:0]           r_cnt, n_cnt;
    logic [ede_pkg::DIST_W-1:0] r_tcnt, n_tcnt;
    logic                       r_drop, n_drop;
    ede_pkg::t_link             r_link, n_link;
    logic                       w_wr_en;

    // decode one transaction
    always_comb begin
        n_cnt  = r_cnt;
        n_tcnt = r_tcnt;
        n_drop = r_drop;
        w_wr_en = 1'b0;
        n_link        = '0;
        n_link.chr    = i_chr;
        if (i_acc) begin
            unique case (i_mode)
                ede_pkg::MODE_REF: begin
                    if (r_tcnt == '0) begin
                        if (r_cnt == CNT_FULL) begin
                            n_drop = 1'b1;
                        end else begin
                            w_wr_en = 1'b1;
                            n_cnt   = r_cnt + 1'b1;
                        end
                    end
                end
                ede_pkg::MODE_TEST: begin
                    n_link.vld   = 1'b1;
                    n_link.d_old = r_tcnt;
                    n_link.d_new = ede_pkg::f_sat_inc(r_tcnt);
                    n_tcnt       = ede_pkg::f_sat_inc(r_tcnt);
                end
                ede_pkg::MODE_END: begin
                    n_link.vld    = 1'b1;
                    n_link.is_end = 1'b1;
                    n_link.d_new  = r_tcnt;
                    n_link.ovf    = r_drop;
                    n_cnt         = '0;
                    n_tcnt        = '0;
                    n_drop        = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // pair state and launch stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_tcnt     <= '0;
            r_drop     <= 1'b0;
            r_link.vld <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_tcnt <= n_tcnt;
            r_drop <= n_drop;
            r_link <= n_link;
        end
    end

    assign o_link   = r_link;
    assign o_wr_en  = w_wr_en;
    assign o_wr_idx = r_cnt;
    assign o_wr_chr = i_chr;

endmodule

/* design/ede_checker.sv */
// ----------------------------------------------------------------------------
// ede_checker - port level checks for the edit distance engine
// Watches the stream ports for result handshake and end token ordering.
// ----------------------------------------------------------------------------
module ede_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    // a pending result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped or changed while stalled");

    // only end transactions are ever held off
    a_stall_end_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> s_axis_tuser == ede_pkg::MODE_END)
        else $error("non-end transaction stalled");

    // an accepted end token cannot report in the next cycle
    a_end_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == ede_pkg::MODE_END
        |=> !m_axis_tvalid)
        else $error("result appeared too early");

    // nothing pending right after reset
    a_reset_clear: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !m_axis_tvalid)
        else $error("result pending after reset");

endmodule

bind edit_distance_engine ede_checker u_ede_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

/* tb/sv/tb_edit_distance_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_edit_distance_engine - self-checking bench for the edit distance engine
// Streams reference and test strings into the engine and tracks the expected
// distance with a behavioral dynamic-programming column. Each result is
// checked against the oldest open pair. Covers empty strings, reference
// overflow, ignored items, output backpressure and random pairs.
// ----------------------------------------------------------------------------
module tb_edit_distance_engine;

    localparam int CAPACITY      = ede_pkg::MAX_LEN_DEF;
    localparam int CLK_HALF      = 5;
    localparam int IDLE_LIMIT    = 5000;
    localparam int RANDOM_ITEMS  = 800;
    localparam logic [ede_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef logic [ede_pkg::CHR_W-1:0] t_byte_q[$];

    typedef struct packed {
        logic [ede_pkg::DIST_W-1:0] distance;
        logic                       overflow;
    } t_edit_result;

    // dut ports
    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata  = '0;   // [7:0] character
    logic [1:0]        s_axis_tuser  = '0;   // [1:0] mode
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [15:0]       m_axis_tdata;         // [15:0] distance
    logic [0:0]        m_axis_tuser;         // [0] overflow

    // expected distances, oldest first
    t_edit_result      pending_results[$];
    t_edit_result      oldest_result;
    int                mismatches    = 0;
    int                items_sent    = 0;
    int                idle_cycles   = 0;

    // idling control shared by sender and receiver
    bit                steady_flow   = 1'b0;
    int                hold_req      = 0;
    int                stall_left    = 0;

    // predicted engine state
    logic [ede_pkg::CHR_W-1:0]  ref_bytes[CAPACITY];
    int                         ref_len;
    logic [ede_pkg::DIST_W-1:0] test_len;
    logic [ede_pkg::DIST_W-1:0] dp_column[CAPACITY+1];
    logic                       ref_dropped;

    edit_distance_engine #(
        .MAX_LEN (CAPACITY)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock
    always #(CLK_HALF) i_clk = ~i_clk;

    // increment that holds at the top of the range
    function automatic logic [ede_pkg::DIST_W-1:0] sat_bump(
        input logic [ede_pkg::DIST_W-1:0] v);
        return (v == {ede_pkg::DIST_W{1'b1}}) ? v : v + 1'b1;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        if (steady_flow)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    // back to an empty pair
    function automatic void clear_pair();
        ref_len     = 0;
        test_len    = '0;
        ref_dropped = 1'b0;
        for (int y = 0; y <= CAPACITY; y++)
            dp_column[y] = ede_pkg::DIST_W'(y);
    endfunction

    // advance the distance column by one accepted transaction
    function automatic void levenshtein_update(input logic [ede_pkg::MODE_W-1:0] mode,
                                               input logic [ede_pkg::CHR_W-1:0] chr);
        logic [ede_pkg::DIST_W-1:0] diag;
        logic [ede_pkg::DIST_W-1:0] upper;
        logic [ede_pkg::DIST_W-1:0] best;
        logic [ede_pkg::DIST_W-1:0] sub;
        case (mode)
            ede_pkg::MODE_REF: begin
                // reference bytes only count before the first test byte
                if (test_len == '0) begin
                    if (ref_len >= CAPACITY)
                        ref_dropped = 1'b1;
                    else begin
                        ref_bytes[ref_len] = chr;
                        ref_len++;
                    end
                end
            end
            ede_pkg::MODE_TEST: begin
                diag         = dp_column[0];
                test_len     = sat_bump(test_len);
                dp_column[0] = test_len;
                for (int y = 1; y <= ref_len; y++) begin
                    sub   = (ref_bytes[y-1] == chr) ? diag : sat_bump(diag);
                    upper = dp_column[y];
                    best  = sat_bump(upper);
                    if (sat_bump(dp_column[y-1]) < best)
                        best = sat_bump(dp_column[y-1]);
                    if (sub < best)
                        best = sub;
                    dp_column[y] = best;
                    diag         = upper;
                end
            end
            ede_pkg::MODE_END: begin
                pending_results.push_back('{distance: dp_column[ref_len],
                                            overflow: ref_dropped});
                clear_pair();
            end
            default: ;
        endcase
    endfunction

    // offer one transaction after a random gap and wait for acceptance
    task automatic send_item(input logic [ede_pkg::MODE_W-1:0] mode,
                             input logic [ede_pkg::CHR_W-1:0] chr);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= chr;
        do @(posedge i_clk); while (!s_axis_tready);
        levenshtein_update(mode, chr);
        items_sent++;
    endtask

    // reference string, test string, then the end transaction
    task automatic send_pair(input t_byte_q ref_s, input t_byte_q test_s);
        foreach (ref_s[i])
            send_item(ede_pkg::MODE_REF, ref_s[i]);
        foreach (test_s[i])
            send_item(ede_pkg::MODE_TEST, test_s[i]);
        send_item(ede_pkg::MODE_END, 8'h00);
    endtask

    function automatic t_byte_q text_bytes(input string s);
        t_byte_q q;
        for (int i = 0; i < s.len(); i++)
            q.push_back(s[i]);
        return q;
    endfunction

    // random bytes, either full range or from a narrow alphabet to get matches
    function automatic t_byte_q random_bytes(input int len, input bit narrow);
        t_byte_q q;
        for (int i = 0; i < len; i++)
            q.push_back(narrow ? ede_pkg::CHR_W'(8'h61 + $urandom_range(0, 3))
                               : ede_pkg::CHR_W'($urandom_range(0, 255)));
        return q;
    endfunction

    function automatic int random_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return $urandom_range(0, 10);
        if (r < 95)
            return $urandom_range(11, 40);
        return $urandom_range(CAPACITY - 4, CAPACITY + 4);
    endfunction

    // empty strings, a classic pair and the byte extremes
    task automatic test_directed_pairs();
        t_byte_q none;
        t_byte_q ext_a;
        t_byte_q ext_b;
        ext_a = '{8'h00, 8'hFF};
        ext_b = '{8'hFF, 8'h00, 8'h00};
        send_pair(none, none);
        send_pair(text_bytes("ab"), none);
        send_pair(none, text_bytes("xyz"));
        send_pair(text_bytes("kitten"), text_bytes("sitting"));
        send_pair(ext_a, ext_b);
    endtask

    // unused mode and reference bytes after test bytes change nothing
    task automatic test_ignored_items();
        send_item(MODE_UNUSED, 8'hFF);
        send_item(ede_pkg::MODE_END, 8'hFF);
        send_item(ede_pkg::MODE_REF, 8'h61);
        send_item(ede_pkg::MODE_REF, 8'h62);
        send_item(ede_pkg::MODE_TEST, 8'h61);
        send_item(ede_pkg::MODE_REF, 8'h7A);
        send_item(MODE_UNUSED, 8'h00);
        send_item(ede_pkg::MODE_TEST, 8'h62);
        send_item(ede_pkg::MODE_END, 8'h00);
    endtask

    // reference beyond capacity sets overflow; the next pair starts clean
    task automatic test_reference_full();
        t_byte_q full_ref;
        full_ref = random_bytes(CAPACITY + 3, 1'b0);
        send_pair(full_ref, random_bytes(5, 1'b1));
        full_ref = random_bytes(CAPACITY, 1'b1);
        send_pair(full_ref, full_ref);
    endtask

    // long receiver hold while the sender keeps offering pairs
    task automatic test_backpressure();
        hold_req = 400;
        for (int p = 0; p < 5; p++)
            send_pair(random_bytes($urandom_range(0, 6), 1'b1),
                      random_bytes($urandom_range(0, 6), 1'b1));
    endtask

    // random pairs with some noise mixed into the test string
    task automatic test_random_pairs();
        t_byte_q ref_s;
        t_byte_q test_s;
        bit      narrow;
        int      target;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target) begin
            steady_flow = ($urandom_range(0, 9) == 0);
            narrow      = 1'($urandom_range(0, 1));
            ref_s       = random_bytes(random_len(), narrow);
            test_s      = random_bytes(random_len(), narrow);
            foreach (ref_s[i])
                send_item(ede_pkg::MODE_REF, ref_s[i]);
            foreach (test_s[i]) begin
                send_item(ede_pkg::MODE_TEST, test_s[i]);
                case ($urandom_range(0, 39))
                    0: send_item(MODE_UNUSED, ede_pkg::CHR_W'($urandom_range(0, 255)));
                    1: send_item(ede_pkg::MODE_REF, ede_pkg::CHR_W'($urandom_range(0, 255)));
                    default: ;
                endcase
            end
            send_item(ede_pkg::MODE_END, ede_pkg::CHR_W'($urandom_range(0, 255)));
            if ($urandom_range(0, 19) == 0)
                send_item(ede_pkg::MODE_END, 8'h00);
        end
        steady_flow = 1'b0;
    endtask

    // receiver: check each result and drive tready with random stalls
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_results.size() == 0) begin
                    $error("unexpected result: distance %0d overflow %0d",
                           m_axis_tdata, m_axis_tuser[0]);
                    mismatches++;
                end else begin
                    oldest_result = pending_results.pop_front();
                    if (m_axis_tdata !== oldest_result.distance) begin
                        $error("distance: expected %0d, actual %0d",
                               oldest_result.distance, m_axis_tdata);
                        mismatches++;
                    end
                    if (m_axis_tuser[0] !== oldest_result.overflow) begin
                        $error("overflow: expected %0d, actual %0d",
                               oldest_result.overflow, m_axis_tuser[0]);
                        mismatches++;
                    end
                end
            end
            if (hold_req != 0) begin
                stall_left = hold_req;
                hold_req   = 0;
            end else if (stall_left == 0 && !steady_flow && $urandom_range(0, 99) < 20)
                stall_left = pick_gap();
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // watchdog: too long without any transaction on either side
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // test sequence
    initial begin
        clear_pair();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_pairs();
        test_ignored_items();
        test_reference_full();
        test_backpressure();
        test_random_pairs();

        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (CAPACITY + 8) @(posedge i_clk);

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* edit_distance_engine.f */
design/ede_pkg.sv
design/ede_cell.sv
design/ede_front.sv
design/edit_distance_engine.sv
design/ede_checker.sv
tb/sv/tb_edit_distance_engine.sv
